### src/cbf_pkg.sv
// Shared types, constants and helper functions for the cubic Bezier flattener.
package cbf_pkg;

    localparam int COORD_W = 32;
    localparam int TB      = 28;              // fraction bits of t and step
    localparam int T_W     = 29;              // t, step, mt: 0..one
    localparam int W_W     = 30;              // Bernstein weights, up to 3*one
    localparam int BASE_W  = 31;              // base and base+step
    localparam int MUL_W   = 33;              // shared multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 68;              // blend accumulator
    localparam int SEG_W   = 48;              // target register width
    localparam int CMP_W   = 64;              // scaled chord compare width
    localparam int CH_W    = 65;              // sum of two squares with carry
    localparam int DIV_W   = 31;              // numerator of the step scaling

    localparam logic [T_W-1:0]   T_ONE   = T_W'(1) << TB;
    localparam logic [T_W-1:0]   T_HALF  = T_W'(1) << (TB - 1);
    localparam logic [T_W-1:0]   T_START = T_W'(26843546);
    // reciprocal of five, exact for any 32 bit numerator
    localparam logic [MUL_W-1:0] DIV5_M  = MUL_W'(33'h0_CCCC_CCCD);
    localparam int               DIV5_SH = 34;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } curve_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic signed [COORD_W-1:0] to_x;
        logic signed [COORD_W-1:0] to_y;
        logic                      last_segment;
        logic                      capped;
    } seg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOOP, ST_T,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
        ST_X0, ST_X1, ST_X2, ST_X3,
        ST_Y0, ST_Y1, ST_Y2, ST_Y3,
        ST_SX, ST_RY, ST_DY, ST_SY,
        ST_SUM, ST_L100, ST_DEC, ST_STEP,
        ST_PUSH, ST_CLOSE, ST_RD, ST_EMIT
    } state_t;

    // product of two t-format values, rounded half up back to t format
    function automatic logic [T_W-1:0] rnd_t(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        s = p + PROD_W'(T_HALF);
        return s[TB +: T_W];
    endfunction

    // weighted sum rounded half up to a coordinate, saturated to 32 bits
    function automatic logic signed [COORD_W-1:0] rnd_sat(
        input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] s;
        s = acc + ACC_W'(T_HALF);
        s = s >>> TB;
        if ((&s[ACC_W-1:COORD_W-1]) || !(|s[ACC_W-1:COORD_W-1]))
            return s[COORD_W-1:0];
        else if (s[ACC_W-1])
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    // magnitude of a difference of two coordinates
    function automatic logic [COORD_W:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? (COORD_W+1)'(-d) : d;
    endfunction

endpackage

### src/cubic_bezier_flattener.sv
// Top level: cubic Bezier flattener, sequencer around one shared multiplier.
//
//  channel   ports                    beat taken when
//  --------  -----------------------  -----------------------
//  curve in  start, busy, curve       start high, busy low
//  segments  seg_valid, seg           seg_valid high (no stall)
//  config    cfg_we, cfg_wdata        cfg_we high
//
// Each trial point runs on the shared multiplier (weights, two blends, two
// squares), plus a step state when the step is rescaled. Each curve point
// adds a loop test and a push; the curve is then closed, and each segment
// is read back from the point store.
// Reset clears the sequencer and sets the target to one unit squared.
// Segments are shown for one cycle each; the receiver cannot stall them.
module cubic_bezier_flattener import cbf_pkg::*; #(
    parameter int MAX_SEGMENTS = 64,
    parameter int RETRY_LIMIT  = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  curve_t           curve,
    output logic             seg_valid,
    output seg_t             seg,
    input  logic             cfg_we,
    input  logic [SEG_W-1:0] cfg_wdata
);

    localparam int AW    = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int RW    = $clog2(RETRY_LIMIT);

    state_t state_reg, state_next;

    // control
    logic [SEG_W-1:0] len_sq_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [AW-1:0]    evals_reg;
    logic [AW-1:0]    k_reg;
    logic [RW-1:0]    retry_reg;
    logic             seg_valid_reg;
    logic             capped_reg;

    // datapath
    curve_t                   curve_reg;
    logic [CMP_W-1:0]         hi_reg, lo_reg;
    logic [BASE_W-1:0]        base_reg;
    logic [T_W-1:0]           step_reg, t_reg, mt_reg, mt2_reg, t2_reg;
    logic [W_W-1:0]           w0_reg, w1_reg, w2_reg, w3_reg;
    logic signed [ACC_W-1:0]  accx_reg, accy_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg, lx_reg, ly_reg;
    logic [COORD_W:0]         dabs_reg;
    logic [CMP_W-1:0]         sqx_reg;
    logic [CH_W-1:0]          chord_reg;
    logic [CMP_W-1:0]         l100_reg;
    point_t                   prev_reg;
    seg_t                     seg_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    point_t                   mem_wdata, mem_rdata;

    logic [BASE_W-1:0] base_step;
    logic [T_W-1:0]    t_now;
    logic              go_on, far, near, accept, moved, at_end, is_last, retry_done;
    logic [CNT_W-1:0]  cnt_close;
    logic [DIV_W-1:0]  v4, v6;
    logic [W_W-1:0]    q5;

    // shared multiplier and point store
    cbf_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    cbf_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (MAX_SEGMENTS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (k_reg),
        .rdata (mem_rdata)
    );

    // loop conditions and tests
    always_comb
    begin
        base_step  = base_reg + BASE_W'(step_reg);
        t_now      = (base_step > BASE_W'(T_ONE)) ? T_ONE : base_step[T_W-1:0];
        go_on      = (base_step < BASE_W'(T_ONE)) &&
                     (evals_reg < AW'(MAX_SEGMENTS - 1));
        far        = l100_reg > hi_reg;
        near       = l100_reg < lo_reg;
        accept     = !far && !near;
        moved      = (x_reg != lx_reg) || (y_reg != ly_reg);
        at_end     = (lx_reg == curve_reg.end_x) && (ly_reg == curve_reg.end_y);
        cnt_close  = cnt_reg + (at_end ? CNT_W'(0) : CNT_W'(1));
        is_last    = (CNT_W'(k_reg) + CNT_W'(1)) == cnt_reg;
        retry_done = retry_reg == RW'(RETRY_LIMIT - 1);
        v4         = DIV_W'({step_reg, 2'b00}) + DIV_W'(2);
        v6         = DIV_W'({step_reg, 2'b00}) + DIV_W'({step_reg, 1'b0}) + DIV_W'(2);
        q5         = prod[DIV5_SH +: W_W];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_LOOP;
            ST_LOOP:  state_next = go_on ? ST_T : ST_CLOSE;
            ST_T:     state_next = ST_M0;
            ST_M0:    state_next = ST_M1;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:    state_next = ST_M4;
            ST_M4:    state_next = ST_M5;
            ST_M5:    state_next = ST_X0;
            ST_X0:    state_next = ST_X1;
            ST_X1:    state_next = ST_X2;
            ST_X2:    state_next = ST_X3;
            ST_X3:    state_next = ST_Y0;
            ST_Y0:    state_next = ST_Y1;
            ST_Y1:    state_next = ST_Y2;
            ST_Y2:    state_next = ST_Y3;
            ST_Y3:    state_next = ST_SX;
            ST_SX:    state_next = ST_RY;
            ST_RY:    state_next = ST_DY;
            ST_DY:    state_next = ST_SY;
            ST_SY:    state_next = ST_SUM;
            ST_SUM:   state_next = ST_L100;
            ST_L100:  state_next = ST_DEC;
            ST_DEC:   state_next = accept ? ST_PUSH : ST_STEP;
            ST_STEP:  state_next = retry_done ? ST_PUSH : ST_T;
            ST_PUSH:  state_next = ST_LOOP;
            ST_CLOSE: state_next = (cnt_close == '0) ? ST_IDLE : ST_RD;
            ST_RD:    state_next = ST_EMIT;
            ST_EMIT:  state_next = is_last ? ST_IDLE : ST_RD;
            default:  state_next = ST_IDLE;
        endcase
    end

    // multiplier operands and point store writes
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = '{x: x_reg, y: y_reg};
        case (state_reg)
            ST_M0:   begin mul_a = MUL_W'(mt_reg);  mul_b = MUL_W'(mt_reg); end
            ST_M1:   begin mul_a = MUL_W'(t_reg);   mul_b = MUL_W'(t_reg);  end
            ST_M2:   begin mul_a = MUL_W'(mt2_reg); mul_b = MUL_W'(mt_reg); end
            ST_M3:   begin mul_a = MUL_W'(mt2_reg); mul_b = MUL_W'(t_reg);  end
            ST_M4:   begin mul_a = MUL_W'(mt_reg);  mul_b = MUL_W'(t2_reg); end
            ST_M5:   begin mul_a = MUL_W'(t2_reg);  mul_b = MUL_W'(t_reg);  end
            ST_X0:   begin mul_a = MUL_W'(w0_reg); mul_b = MUL_W'(curve_reg.start_x); end
            ST_X1:   begin mul_a = MUL_W'(w1_reg); mul_b = MUL_W'(curve_reg.ctrl1_x); end
            ST_X2:   begin mul_a = MUL_W'(w2_reg); mul_b = MUL_W'(curve_reg.ctrl2_x); end
            ST_X3:   begin mul_a = MUL_W'(w3_reg); mul_b = MUL_W'(curve_reg.end_x);   end
            ST_Y0:   begin mul_a = MUL_W'(w0_reg); mul_b = MUL_W'(curve_reg.start_y); end
            ST_Y1:   begin mul_a = MUL_W'(w1_reg); mul_b = MUL_W'(curve_reg.ctrl1_y); end
            ST_Y2:   begin mul_a = MUL_W'(w2_reg); mul_b = MUL_W'(curve_reg.ctrl2_y); end
            ST_Y3:   begin mul_a = MUL_W'(w3_reg); mul_b = MUL_W'(curve_reg.end_y);   end
            ST_SX, ST_SY:
            begin
                // magnitude 2^32 has zero low word, matching the 64 bit wrap
                mul_a = MUL_W'(dabs_reg[COORD_W-1:0]);
                mul_b = MUL_W'(dabs_reg[COORD_W-1:0]);
            end
            ST_DEC:
            begin
                mul_a = far ? MUL_W'(v4) : MUL_W'(v6);
                mul_b = DIV5_M;
            end
            ST_PUSH:  mem_we = moved;
            ST_CLOSE:
            begin
                mem_we    = !at_end;
                mem_wdata = '{x: curve_reg.end_x, y: curve_reg.end_y};
            end
            default:  ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_sq_reg    <= SEG_W'(1) << FRAC_BITS;
            cnt_reg       <= '0;
            evals_reg     <= '0;
            k_reg         <= '0;
            retry_reg     <= '0;
            seg_valid_reg <= 1'b0;
            capped_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_valid_reg <= state_reg == ST_EMIT;
            if (cfg_we)
                len_sq_reg <= cfg_wdata;
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg   <= '0;
                    evals_reg <= '0;
                    k_reg     <= '0;
                end
                ST_LOOP:
                begin
                    if (go_on)
                    begin
                        evals_reg <= evals_reg + AW'(1);
                        retry_reg <= RW'(1);
                    end
                    else
                        capped_reg <= base_step < BASE_W'(T_ONE);
                end
                ST_STEP:  if (!retry_done) retry_reg <= retry_reg + RW'(1);
                ST_PUSH:  if (moved) cnt_reg <= cnt_reg + CNT_W'(1);
                ST_CLOSE: cnt_reg <= cnt_close;
                ST_EMIT:  k_reg <= k_reg + AW'(1);
                default:  ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                curve_reg <= curve;
                lx_reg    <= curve.start_x;
                ly_reg    <= curve.start_y;
                base_reg  <= '0;
                step_reg  <= T_START;
                hi_reg    <= CMP_W'(len_sq_reg) * CMP_W'(105);
                lo_reg    <= CMP_W'(len_sq_reg) * CMP_W'(95);
            end
            ST_T:
            begin
                t_reg  <= t_now;
                mt_reg <= T_ONE - t_now;
            end
            ST_M1:   mt2_reg <= rnd_t(prod);
            ST_M2:   t2_reg  <= rnd_t(prod);
            ST_M3:   w0_reg  <= W_W'(rnd_t(prod));
            ST_M4:   w1_reg  <= W_W'(rnd_t(prod)) * W_W'(3);
            ST_M5:   w2_reg  <= W_W'(rnd_t(prod)) * W_W'(3);
            ST_X0:   w3_reg  <= W_W'(rnd_t(prod));
            ST_X1:   accx_reg <= ACC_W'(prod);
            ST_X2, ST_X3, ST_Y0:
                     accx_reg <= accx_reg + ACC_W'(prod);
            ST_Y1:
            begin
                accy_reg <= ACC_W'(prod);
                x_reg    <= rnd_sat(accx_reg);
            end
            ST_Y2:
            begin
                accy_reg <= accy_reg + ACC_W'(prod);
                dabs_reg <= abs_diff(x_reg, lx_reg);
            end
            ST_Y3, ST_SX:
                     accy_reg <= accy_reg + ACC_W'(prod);
            ST_RY:
            begin
                sqx_reg <= prod[CMP_W-1:0];
                y_reg   <= rnd_sat(accy_reg);
            end
            ST_DY:   dabs_reg <= abs_diff(y_reg, ly_reg);
            ST_SUM:  chord_reg <= ({1'b0, sqx_reg} + {1'b0, prod[CMP_W-1:0]}) >> FRAC_BITS;
            ST_L100: l100_reg <= CMP_W'(chord_reg * CH_W'(100));
            ST_STEP: step_reg <= (q5 > W_W'(T_ONE)) ? T_ONE : q5[T_W-1:0];
            ST_PUSH:
            begin
                base_reg <= base_step;
                if (moved)
                begin
                    lx_reg <= x_reg;
                    ly_reg <= y_reg;
                end
            end
            ST_CLOSE: prev_reg <= '{x: curve_reg.start_x, y: curve_reg.start_y};
            ST_EMIT:
            begin
                seg_reg.from_x       <= prev_reg.x;
                seg_reg.from_y       <= prev_reg.y;
                seg_reg.to_x         <= mem_rdata.x;
                seg_reg.to_y         <= mem_rdata.y;
                seg_reg.last_segment <= is_last;
                seg_reg.capped       <= capped_reg;
                prev_reg             <= mem_rdata;
            end
            default: ;
        endcase
    end

    assign busy      = state_reg != ST_IDLE;
    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count past limit");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && state_reg != ST_LOOP) |-> (step_reg != '0 && step_reg <= T_ONE))
        else $error("step out of range");

    a_beat_src: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> $past(state_reg == ST_EMIT))
        else $error("segment beat without read-back");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_valid && seg.last_segment) |-> state_reg == ST_IDLE)
        else $error("final beat while still busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted curve not taken up");

endmodule

### src/cbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/cbf_mul.sv
// Shared signed multiplier with a registered product.
module cbf_mul import cbf_pkg::*; (
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule
